// ===== rtl/core/bsat_pkg.sv =====
// bsat_pkg: shared constants, beat type and tangent table builder for the
// bisection atan2 angle block. No dependencies.
`timescale 1ns / 1ps

package bsat_pkg;

	localparam int COORD_BITS   = 16;
	localparam int BISECT_STEPS = 10;
	localparam int FINE_BITS    = 4;
	localparam int TESTS        = BISECT_STEPS - 1;
	localparam int D_W          = COORD_BITS + 1;
	localparam int FINE_W       = 10 + FINE_BITS;
	localparam int TAN_W        = 26;
	localparam int FRAC_W       = 16;
	localparam int PROD_W       = D_W + TAN_W;
	localparam int ANGLE_W      = 12;
	localparam int ROW_W        = TESTS - 1;
	localparam int ROW_N        = 1 << ROW_W;
	localparam int MID_SHIFT    = FINE_W - 1 - TESTS;

	localparam logic [ANGLE_W:0] ANG_QUARTER = (ANGLE_W + 1)'(1 << (ANGLE_W - 2));
	localparam logic [ANGLE_W:0] ANG_HALF    = (ANGLE_W + 1)'(1 << (ANGLE_W - 1));
	localparam logic [ANGLE_W:0] ANG_FULL    = (ANGLE_W + 1)'(1 << ANGLE_W);

	localparam logic [63:0] TAN_MAX     = 64'h3FF_FFFF;
	localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
	localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] QUARTER_FIN = 64'(1 << FINE_W);
	localparam logic [63:0] HALF_FIN    = 64'(1 << (FINE_W - 1));

	typedef struct packed {
		logic [D_W-1:0]   ax;
		logic [D_W-1:0]   ay;
		logic             neg_x;
		logic             neg_y;
		logic             zero_x;
		logic             zero_y;
		logic [TESTS-1:0] pfx;
	} bsat_beat_t;

	typedef logic [TAN_W-1:0] tan_row_t [ROW_N];

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al  = {32'b0, a[31:0]};
		ah  = {32'b0, a[63:32]};
		bl  = {32'b0, b[31:0]};
		bh  = {32'b0, b[63:32]};
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = {32'b0, ll[63:32]} + {32'b0, lh[31:0]} + {32'b0, hl[31:0]};
		lo  = {mid[31:0], ll[31:0]};
		hi  = hh + {32'b0, lh[63:32]} + {32'b0, hl[63:32]} + {32'b0, mid[63:32]};
		return (hi << 4) | (lo >> 60);
	endfunction

	function automatic logic [63:0] sin_den_div(input logic [63:0] t, input logic [4:0] n);
		logic [63:0] q;
		case (n)
			5'd1:    q = t / 64'd6;
			5'd2:    q = t / 64'd20;
			5'd3:    q = t / 64'd42;
			5'd4:    q = t / 64'd72;
			5'd5:    q = t / 64'd110;
			5'd6:    q = t / 64'd156;
			5'd7:    q = t / 64'd210;
			5'd8:    q = t / 64'd272;
			5'd9:    q = t / 64'd342;
			5'd10:   q = t / 64'd420;
			5'd11:   q = t / 64'd506;
			5'd12:   q = t / 64'd600;
			5'd13:   q = t / 64'd702;
			5'd14:   q = t / 64'd812;
			5'd15:   q = t / 64'd930;
			5'd16:   q = t / 64'd1056;
			5'd17:   q = t / 64'd1190;
			5'd18:   q = t / 64'd1332;
			5'd19:   q = t / 64'd1482;
			5'd20:   q = t / 64'd1640;
			5'd21:   q = t / 64'd1806;
			5'd22:   q = t / 64'd1980;
			5'd23:   q = t / 64'd2162;
			5'd24:   q = t / 64'd2352;
			5'd25:   q = t / 64'd2550;
			5'd26:   q = t / 64'd2756;
			5'd27:   q = t / 64'd2970;
			5'd28:   q = t / 64'd3192;
			5'd29:   q = t / 64'd3422;
			default: q = t;
		endcase
		return q;
	endfunction

	function automatic logic [63:0] cos_den_div(input logic [63:0] t, input logic [4:0] n);
		logic [63:0] q;
		case (n)
			5'd1:    q = t / 64'd2;
			5'd2:    q = t / 64'd12;
			5'd3:    q = t / 64'd30;
			5'd4:    q = t / 64'd56;
			5'd5:    q = t / 64'd90;
			5'd6:    q = t / 64'd132;
			5'd7:    q = t / 64'd182;
			5'd8:    q = t / 64'd240;
			5'd9:    q = t / 64'd306;
			5'd10:   q = t / 64'd380;
			5'd11:   q = t / 64'd462;
			5'd12:   q = t / 64'd552;
			5'd13:   q = t / 64'd650;
			5'd14:   q = t / 64'd756;
			5'd15:   q = t / 64'd870;
			5'd16:   q = t / 64'd992;
			5'd17:   q = t / 64'd1122;
			5'd18:   q = t / 64'd1260;
			5'd19:   q = t / 64'd1406;
			5'd20:   q = t / 64'd1560;
			5'd21:   q = t / 64'd1722;
			5'd22:   q = t / 64'd1892;
			5'd23:   q = t / 64'd2070;
			5'd24:   q = t / 64'd2256;
			5'd25:   q = t / 64'd2450;
			5'd26:   q = t / 64'd2652;
			5'd27:   q = t / 64'd2862;
			5'd28:   q = t / 64'd3080;
			5'd29:   q = t / 64'd3306;
			default: q = t;
		endcase
		return q;
	endfunction

	function automatic logic [63:0] sin_q60(input logic [63:0] phi);
		logic [63:0] p2, term, sv;
		p2   = mul_q60(phi, phi);
		term = phi;
		sv   = phi;
		for (int n = 1; n < 30; n++) begin
			if (term != 64'd0) begin
				term = sin_den_div(mul_q60(term, p2), 5'(n));
				sv   = (n % 2 == 1) ? sv - term : sv + term;
			end
		end
		return sv;
	endfunction

	function automatic logic [63:0] cos_q60(input logic [63:0] phi);
		logic [63:0] p2, term, cv;
		p2   = mul_q60(phi, phi);
		term = Q60_ONE;
		cv   = Q60_ONE;
		for (int n = 1; n < 30; n++) begin
			if (term != 64'd0) begin
				term = cos_den_div(mul_q60(term, p2), 5'(n));
				cv   = (n % 2 == 1) ? cv - term : cv + term;
			end
		end
		return cv;
	endfunction

	// round(n * 2^16 / d), saturated
	function automatic logic [63:0] div_q16(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r, q;
		logic        sat, nb;
		r   = 64'd0;
		q   = 64'd0;
		sat = (d == 64'd0);
		for (int i = 62 + FRAC_W; i >= 0; i--) begin
			if (!sat) begin
				nb = 1'b0;
				if (i >= FRAC_W) begin
					nb = n[i - FRAC_W];
				end
				r = {r[62:0], nb};
				q = {q[62:0], 1'b0};
				if (r >= d) begin
					r = r - d;
					q = q | 64'd1;
				end
				if (q > TAN_MAX) begin
					sat = 1'b1;
				end
			end
		end
		if (!sat) begin
			if (r >= d - r) begin
				q = q + 64'd1;
			end
			if (q > TAN_MAX) begin
				sat = 1'b1;
			end
		end
		return sat ? TAN_MAX : q;
	endfunction

	function automatic logic [63:0] tan_rom(input logic [FINE_W:0] k);
		logic [63:0] step, kk, phi, res;
		step = PI_Q60 >> (11 + FINE_BITS);
		kk   = 64'(k);
		if (kk == 64'd0) begin
			res = 64'd0;
		end else if (kk >= QUARTER_FIN) begin
			res = TAN_MAX;
		end else if (kk <= HALF_FIN) begin
			phi = kk * step;
			res = div_q16(sin_q60(phi), cos_q60(phi));
		end else begin
			phi = (QUARTER_FIN - kk) * step;
			res = div_q16(cos_q60(phi), sin_q60(phi));
		end
		return res;
	endfunction

	// tangent at every midpoint tested by one cell, indexed by its prefix
	function automatic tan_row_t tan_row(input int level);
		tan_row_t        row;
		logic [FINE_W:0] k;
		for (int p = 0; p < ROW_N; p++) begin
			if (p < (1 << level)) begin
				k              = (FINE_W + 1)'((2 * p + 1) << (FINE_W - 1 - level));
				row[ROW_W'(p)] = TAN_W'(tan_rom(k));
			end else begin
				row[ROW_W'(p)] = '0;
			end
		end
		return row;
	endfunction

endpackage

// ===== rtl/core/bisection_atan2_angle_top.sv =====
// bisection_atan2_angle_top: quantized angle of a point about an origin by a
// chain of bisection cells. Uses bsat_pkg, bsat_prep and bsat_cell.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, x_pos, y_pos,        | sink
//           | origin_x, origin_y                       |
//   out     | out_valid, out_stall, angle              | source
//
// one beat per cycle while the skid register is empty; the path runs through
// an input stage, two registers in each of the nine cells, an output stage
// reset clears all valid bits and the skid register; no clearing pass
// a stalled result parks in a one-entry skid register; in_stall is that
// register's full flag, so the chain only halts while the skid holds a beat
`timescale 1ns / 1ps

module bisection_atan2_angle_top import bsat_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_pos,
	input  logic signed [COORD_BITS-1:0] y_pos,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ANGLE_W-1:0]           angle
);

	logic                adv;
	logic [TESTS:0]      vld;
	bsat_beat_t          beat [TESTS+1];
	logic [TAN_W-1:0]    tan_mid [TESTS];
	logic [FINE_W-1:0]   mid_fine;
	logic [ANGLE_W:0]    a_fold;
	logic                out_vld_s;
	logic [ANGLE_W-1:0]  angle_s;
	logic                skid_q;
	logic [ANGLE_W-1:0]  skid_angle_q;

	assign adv      = ~skid_q;
	assign in_stall = skid_q;

	bsat_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.x_pos    (x_pos),
		.y_pos    (y_pos),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.vld_s1   (vld[0]),
		.beat_s1  (beat[0])
	);

	for (genvar g = 0; g < TESTS; g++) begin : g_cell
		localparam tan_row_t TAN_ROW = tan_row(g);

		assign tan_mid[g] = TAN_ROW[beat[g].pfx[ROW_W-1:0]];

		bsat_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.left_vld  (vld[g]),
			.left      (beat[g]),
			.tan_mid   (tan_mid[g]),
			.right_vld (vld[g+1]),
			.right     (beat[g+1])
		);
	end

	// final midpoint, special cases, then quadrant fold
	always_comb begin
		mid_fine = FINE_W'({beat[TESTS].pfx, 1'b1}) << MID_SHIFT;
		if (beat[TESTS].zero_x) begin
			a_fold = ANG_QUARTER;
		end else if (beat[TESTS].zero_y) begin
			a_fold = '0;
		end else begin
			a_fold = (ANGLE_W + 1)'(mid_fine[FINE_W-1:FINE_BITS]);
		end
		if (beat[TESTS].neg_x) begin
			a_fold = ANG_HALF - a_fold;
		end
		if (beat[TESTS].neg_y) begin
			a_fold = ANG_FULL - a_fold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
			skid_q    <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_s <= vld[TESTS];
			end
			if (skid_q) begin
				if (!out_stall) begin
					skid_q <= 1'b0;
				end
			end else if (out_vld_s && out_stall) begin
				skid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s <= a_fold[ANGLE_W-1:0];
		end
		if (!skid_q && out_vld_s && out_stall) begin
			skid_angle_q <= angle_s;
		end
	end

	assign out_valid = skid_q | out_vld_s;
	assign angle     = skid_q ? skid_angle_q : angle_s;

	// a full skid always presents its beat
	a_skid_shown: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_valid)
		else $error("skid full but no output beat");

	// a stalled result from the output stage is never dropped
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_q && out_vld_s && out_stall |=> skid_q && skid_angle_q == $past(angle_s))
		else $error("stalled result not captured in skid");

	// the chain holds still while the skid is full
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |=> $stable(out_vld_s) && $stable(vld))
		else $error("pipeline moved while skid full");

endmodule

// ===== rtl/core/bsat_prep.sv =====
// bsat_prep: input register stage, forms |dx|, |dy|, quadrant signs and
// zero flags. Depends on bsat_pkg.
`timescale 1ns / 1ps

module bsat_prep import bsat_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] x_pos,
	input  logic signed [COORD_BITS-1:0] y_pos,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	output logic                         vld_s1,
	output bsat_beat_t                   beat_s1
);

	logic signed [D_W-1:0] dx, dy;
	bsat_beat_t            beat_d;

	always_comb begin
		dx = D_W'(x_pos) - D_W'(origin_x);
		dy = D_W'(y_pos) - D_W'(origin_y);
		beat_d.neg_x  = dx[D_W-1];
		beat_d.neg_y  = dy[D_W-1];
		beat_d.ax     = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		beat_d.ay     = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		beat_d.zero_x = (dx == '0);
		beat_d.zero_y = (dy == '0);
		beat_d.pfx    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s1 <= beat_d;
		end
	end

endmodule

// ===== rtl/core/bsat_cell.sv =====
// bsat_cell: one bisection step; registers the tangent of its midpoint, then
// compares |dy| * 2^16 against |dx| * tan and extends the prefix. Uses bsat_pkg.
`timescale 1ns / 1ps

module bsat_cell import bsat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             left_vld,
	input  bsat_beat_t       left,
	input  logic [TAN_W-1:0] tan_mid,
	output logic             right_vld,
	output bsat_beat_t       right
);

	logic              vld_s1;
	bsat_beat_t        beat_s1;
	logic [TAN_W-1:0]  tan_s1;
	logic [PROD_W-1:0] prod, y_ref;
	logic              below;
	bsat_beat_t        beat_d;

	always_comb begin
		prod   = PROD_W'(beat_s1.ax) * PROD_W'(tan_s1);
		y_ref  = PROD_W'({beat_s1.ay, FRAC_W'(0)});
		below  = (y_ref < prod);
		beat_d = beat_s1;
		beat_d.pfx = {beat_s1.pfx[TESTS-2:0], ~below};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			right_vld <= 1'b0;
		end else if (adv) begin
			vld_s1    <= left_vld;
			right_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s1 <= left;
			tan_s1  <= tan_mid;
			right   <= beat_d;
		end
	end

endmodule
